### rtl/dsrs_pkg.sv
// Shared types, constants and the CRC step of the dual slot record selector.
`default_nettype none

package dsrs_pkg;

  // Slot image layout and checks
  localparam logic [15:0] MAGIC_RESET = 16'hA5C3;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam int unsigned HDR_BYTES   = 6;
  localparam int unsigned TRAILER     = 8;

  // Byte positions of the header fields
  localparam int unsigned POS_MAGIC_LO = 0;
  localparam int unsigned POS_MAGIC_HI = 1;
  localparam int unsigned POS_SEQ_LO   = 2;
  localparam int unsigned POS_SEQ_HI   = 3;
  localparam int unsigned POS_LEN      = 4;

  // Queue depths
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    PICK_A    = 2'd0,
    PICK_B    = 2'd1,
    PICK_NONE = 2'd2
  } pick_e;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_e;

  // One emission run, handed from front to back
  typedef struct packed {
    pick_e       pick;
    logic [15:0] seq;
    logic        a_valid;
    logic        b_valid;
    logic [4:0]  len;
    logic        bank;
  } job_t;

  // Payload store write port
  typedef struct packed {
    logic       en;
    logic       bank;
    logic       slot;
    logic [4:0] idx;
    logic [7:0] data;
  } mem_wr_t;

  // Payload store read port
  typedef struct packed {
    logic       en;
    logic       bank;
    logic       slot;
    logic [4:0] idx;
  } mem_rd_t;

  // One result transaction
  typedef struct packed {
    pick_e       pick;
    logic [15:0] seq;
    logic        a_valid;
    logic        b_valid;
    logic [7:0]  data;
    logic [4:0]  idx;
    logic        last;
  } result_t;

  // Advance CRC-16/CCITT by one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/dsrs_front.sv
// Front end: parses slot images, checks them and issues emission runs.
`default_nettype none

module dsrs_front
  import dsrs_pkg::*;
#(
  parameter int SLOT_BYTES = 32,
  parameter int RECORD_LEN = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        slot_id_i,
  input  wire logic        slot_last_i,
  input  wire logic        read_fault_i,
  output mem_wr_t          mem_wr_o,
  output logic             job_push_o,
  output job_t             job_o
);

  localparam int PW = $clog2(SLOT_BYTES + 1);
  localparam logic [8:0] HDR9     = 9'(HDR_BYTES);
  localparam logic [8:0] REC9     = 9'(RECORD_LEN);
  localparam logic [8:0] LEN_MAX9 = 9'(SLOT_BYTES - TRAILER);

  logic [15:0]      magic_q;
  logic [PW-1:0]    pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      mcap_q, mcap_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      scrc_q, scrc_d;
  logic             fault_q, fault_d;
  logic [1:0][15:0] seq_q, seq_d;
  logic [1:0][4:0]  slen_q, slen_d;
  logic [1:0]       valid_q, valid_d;
  logic             wbank_q, wbank_d;

  logic       active;
  logic [7:0] len_cur;
  logic [8:0] p9, len9, hdr_end, cnt9;
  logic       ok;
  logic [4:0] len_clip;
  logic [15:0] seq_diff;
  pick_e      win;

  // Hold the expected marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MAGIC_RESET;
    end else if (cfg_we_i) begin
      magic_q <= cfg_wdata_i;
    end
  end

  // Decode the current byte position against the captured length
  assign active   = (pos_q < PW'(SLOT_BYTES));
  assign len_cur  = (pos_q == PW'(POS_LEN)) ? data_byte_i : len_q;
  assign p9       = 9'(pos_q);
  assign len9     = {1'b0, len_cur};
  assign hdr_end  = HDR9 + len9;

  // Parse, check and issue
  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    mcap_d   = mcap_q;
    len_d    = len_q;
    scrc_d   = scrc_q;
    fault_d  = fault_q;
    seq_d    = seq_q;
    slen_d   = slen_q;
    valid_d  = valid_q;
    wbank_d  = wbank_q;
    mem_wr_o = '{en: 1'b0, bank: wbank_q, slot: slot_id_i,
                 idx: 5'(p9 - HDR9), data: data_byte_i};
    job_push_o = 1'b0;
    job_o      = '{pick: PICK_NONE, seq: 16'h0, a_valid: 1'b0, b_valid: 1'b0,
                   len: 5'd0, bank: wbank_q};
    cnt9     = '0;
    ok       = 1'b0;
    len_clip = '0;
    seq_diff = '0;
    win      = PICK_NONE;

    if (accept_i) begin
      if (read_fault_i) begin
        fault_d = 1'b1;
      end
      if (active) begin
        len_d = len_cur;
        case (pos_q)
          PW'(POS_MAGIC_LO): mcap_d[7:0]             = data_byte_i;
          PW'(POS_MAGIC_HI): mcap_d[15:8]            = data_byte_i;
          PW'(POS_SEQ_LO):   seq_d[slot_id_i][7:0]  = data_byte_i;
          PW'(POS_SEQ_HI):   seq_d[slot_id_i][15:8] = data_byte_i;
          default: ;
        endcase
        if (p9 >= 9'(POS_SEQ_LO) && p9 < hdr_end) begin
          crc_d = crc_byte(crc_q, data_byte_i);
        end
        if (p9 >= HDR9 && p9 < hdr_end && (p9 - HDR9) < REC9) begin
          mem_wr_o.en = 1'b1;
        end
        if (p9 == hdr_end) begin
          scrc_d[7:0] = data_byte_i;
        end else if (p9 == hdr_end + 9'd1) begin
          scrc_d[15:8] = data_byte_i;
        end
        pos_d = pos_q + PW'(1);
      end

      if (slot_last_i) begin
        // Judge the slot
        cnt9 = 9'(pos_d);
        ok = !fault_d && (mcap_d == magic_q) && (len_d != 8'd0)
             && ({1'b0, len_d} <= LEN_MAX9)
             && (cnt9 >= {1'b0, len_d} + 9'(TRAILER)) && (crc_d == scrc_d);
        len_clip = ({1'b0, len_d} < REC9) ? 5'(len_d) : 5'(RECORD_LEN);
        valid_d[slot_id_i] = ok;
        slen_d[slot_id_i]  = ok ? len_clip : 5'd0;

        // Clear the frame
        pos_d   = '0;
        crc_d   = CRC_INIT;
        mcap_d  = '0;
        len_d   = '0;
        scrc_d  = '0;
        fault_d = 1'b0;

        if (slot_id_i) begin
          // Pick the newer valid slot and issue its run, or a run for neither slot
          seq_diff = seq_d[0] - seq_d[1];
          if (valid_d[0] && valid_d[1]) begin
            win = seq_diff[15] ? PICK_B : PICK_A;
          end else if (valid_d[0]) begin
            win = PICK_A;
          end else if (valid_d[1]) begin
            win = PICK_B;
          end else begin
            win = PICK_NONE;
          end
          job_push_o = 1'b1;
          if (win != PICK_NONE) begin
            job_o.pick    = win;
            job_o.seq     = seq_d[win == PICK_B];
            job_o.a_valid = valid_d[0];
            job_o.b_valid = valid_d[1];
            job_o.len     = slen_d[win == PICK_B];
          end
          wbank_d = !wbank_q;
          valid_d = '0;
        end
      end
    end
  end

  // Frame and slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CRC_INIT;
      mcap_q  <= '0;
      len_q   <= '0;
      scrc_q  <= '0;
      fault_q <= 1'b0;
      seq_q   <= '0;
      slen_q  <= '0;
      valid_q <= '0;
      wbank_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      mcap_q  <= mcap_d;
      len_q   <= len_d;
      scrc_q  <= scrc_d;
      fault_q <= fault_d;
      seq_q   <= seq_d;
      slen_q  <= slen_d;
      valid_q <= valid_d;
      wbank_q <= wbank_d;
    end
  end

endmodule

`default_nettype wire

### rtl/dsrs_job_queue.sv
// Two-entry queue of emission runs between front and back.
`default_nettype none

module dsrs_job_queue
  import dsrs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      head_valid_o,
  output job_t      head_o
);

  localparam int CW = $clog2(JOB_DEPTH + 1);
  localparam int AW = $clog2(JOB_DEPTH);

  job_t          entry_q [JOB_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o       = (cnt_q == CW'(JOB_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  // Store pushed runs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dsrs_payload_ram.sv
// Payload store: two banks of two slots, one write and one registered read port.
`default_nettype none

module dsrs_payload_ram
  import dsrs_pkg::*;
#(
  parameter int RECORD_LEN = 24
) (
  input  wire logic  clk_i,
  input  mem_wr_t    wr_i,
  input  mem_rd_t    rd_i,
  output logic [7:0] rdata_o
);

  localparam int DEPTH = 4 * RECORD_LEN;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    mem_q [DEPTH];
  logic [AW-1:0] wr_addr, rd_addr;

  // Map bank, slot and offset to a flat address
  assign wr_addr = AW'({wr_i.bank, wr_i.slot}) * AW'(RECORD_LEN) + AW'(wr_i.idx);
  assign rd_addr = AW'({rd_i.bank, rd_i.slot}) * AW'(RECORD_LEN) + AW'(rd_i.idx);

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr] <= wr_i.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_o <= mem_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/dsrs_back.sv
// Back end: walks an emission run through the payload store into the result queue.
`default_nettype none

module dsrs_back
  import dsrs_pkg::*;
#(
  parameter int RECORD_LEN = 24
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  job_t       head_i,
  output logic       job_pop_o,
  output mem_rd_t    mem_rd_o,
  input  wire logic [7:0] rdata_i,
  input  wire logic  pop_i,
  output logic       empty_o,
  output result_t    result_o
);

  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam int AW = $clog2(OUT_DEPTH);

  back_state_e   state_q, state_d;
  logic [4:0]    k_q, k_d;
  logic          s_vld_q;
  logic [4:0]    s_k_q;
  logic          s_last_q;
  job_t          s_job_q;

  result_t       out_q [OUT_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  logic          space;
  logic          issue;
  logic          last_issue;
  logic [4:0]    run_end;
  logic          out_pop;
  result_t       res;

  assign space      = ({1'b0, cnt_q} + (CW + 1)'(s_vld_q)) < (CW + 1)'(OUT_DEPTH);
  assign run_end    = (head_i.pick == PICK_NONE) ? 5'd0 : 5'(RECORD_LEN - 1);
  assign last_issue = (k_q == run_end);

  // Sequence the run, one read per cycle while the result queue has room
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    issue     = 1'b0;
    job_pop_o = 1'b0;
    case (state_q)
      BACK_IDLE: begin
        if (head_valid_i) begin
          state_d = BACK_RUN;
          k_d     = '0;
        end
      end
      BACK_RUN: begin
        if (space) begin
          issue = 1'b1;
          k_d   = k_q + 5'd1;
          if (last_issue) begin
            job_pop_o = 1'b1;
            state_d   = BACK_IDLE;
          end
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  assign mem_rd_o = '{en: issue, bank: head_i.bank, slot: (head_i.pick == PICK_B),
                      idx: k_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_IDLE;
      k_q     <= '0;
      s_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      s_vld_q <= issue;
    end
  end

  // Track the read in flight
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s_k_q    <= k_q;
      s_last_q <= last_issue;
      s_job_q  <= head_i;
    end
  end

  // Build the result; zero past the stored length
  always_comb begin
    res.pick    = s_job_q.pick;
    res.seq     = s_job_q.seq;
    res.a_valid = s_job_q.a_valid;
    res.b_valid = s_job_q.b_valid;
    res.data    = (s_k_q < s_job_q.len) ? rdata_i : 8'h00;
    res.idx     = s_k_q;
    res.last    = s_last_q;
  end

  // Result queue
  assign empty_o  = (cnt_q == '0);
  assign out_pop  = pop_i && !empty_o;
  assign result_o = out_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (s_vld_q) begin
      out_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s_vld_q) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (s_vld_q && !out_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (out_pop && !s_vld_q) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dual_slot_record_selector_core.sv
// Slot B's last byte pushes a run that passes the job queue, the back end's run state, the
// registered payload read and the result queue. Throughput: one byte per cycle is accepted
// while full is low; a run drains at one result per cycle while the result queue has room,
// RECORD_LEN results for a chosen slot or one result when neither slot is valid, and the
// back end passes its idle state between runs. Input stalls (full) only while the job queue
// holds two runs, the one being drained and one behind it (two payload banks).
// Reset clears all control state and sets the marker to A5C3; the payload store is not cleared.
`default_nettype none

module dual_slot_record_selector_core
  import dsrs_pkg::*;
#(
  parameter int SLOT_BYTES = 32,
  parameter int RECORD_LEN = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        slot_id_i,
  input  wire logic        slot_last_i,
  input  wire logic        read_fault_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       pick_status_o,
  output logic [15:0]      chosen_seq_o,
  output logic             a_valid_o,
  output logic             b_valid_o,
  output logic [7:0]       record_byte_o,
  output logic [4:0]       byte_index_o,
  output logic             run_last_o
);

  logic    accept;
  mem_wr_t mem_wr;
  mem_rd_t mem_rd;
  logic [7:0] rdata;
  logic    job_push, job_pop, job_full, head_valid;
  job_t    job, head;
  result_t result;

  assign accept = push && !job_full;
  assign full   = job_full;

  dsrs_front #(
    .SLOT_BYTES(SLOT_BYTES),
    .RECORD_LEN(RECORD_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .slot_id_i   (slot_id_i),
    .slot_last_i (slot_last_i),
    .read_fault_i(read_fault_i),
    .mem_wr_o    (mem_wr),
    .job_push_o  (job_push),
    .job_o       (job)
  );

  dsrs_job_queue u_job_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .job_i       (job),
    .pop_i       (job_pop),
    .full_o      (job_full),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  dsrs_payload_ram #(
    .RECORD_LEN(RECORD_LEN)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .wr_i   (mem_wr),
    .rd_i   (mem_rd),
    .rdata_o(rdata)
  );

  dsrs_back #(
    .RECORD_LEN(RECORD_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .job_pop_o   (job_pop),
    .mem_rd_o    (mem_rd),
    .rdata_i     (rdata),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result)
  );

  // Drive the result ports from the queue head
  assign pick_status_o = result.pick;
  assign chosen_seq_o  = result.seq;
  assign a_valid_o     = result.a_valid;
  assign b_valid_o     = result.b_valid;
  assign record_byte_o = result.data;
  assign byte_index_o  = result.idx;
  assign run_last_o    = result.last;

endmodule

`default_nettype wire

### bench/tb.sv
// Testbench of the dual slot record selector: slot image stimulus, prediction and result checks.
`timescale 1ns / 1ps

import dsrs_pkg::*;

// Advance CRC-16/CCITT by one byte, one feedback bit per data bit, MSB first
function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
  logic [15:0] c;
  logic fb;
  c = crc;
  for (int i = 7; i >= 0; i--) begin
    fb = c[15] ^ b[i];
    c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
  end
  return c;
endfunction

// One expected result transaction
typedef struct packed {
  pick_e       pick;
  logic [15:0] seq;
  logic        a_ok;
  logic        b_ok;
  logic [7:0]  data;
  logic [4:0]  idx;
  logic        last;
} record_beat_t;

// Tracks slot verdicts and payloads, and holds the record beats still due
class record_pick_board #(int SLOT = 32, int REC = 24);
  logic [15:0]  marker;
  logic [5:0]   pos;
  logic [15:0]  crc;
  logic [15:0]  magic_cap;
  logic [7:0]   len_cap;
  logic [15:0]  crc_cap;
  logic         fault_cap;
  logic [15:0]  seq_of [2];
  logic [4:0]   kept_len [2];
  logic         ok_of [2];
  logic [7:0]   payload [2][REC];
  record_beat_t due_beats [$];
  int           mismatches;
  int           beats_checked;
  int           picks_a;
  int           picks_b;
  int           picks_none;

  function new();
    marker = MAGIC_RESET;
    clear_frame();
    for (int s = 0; s < 2; s++) begin
      seq_of[s] = '0;
      kept_len[s] = '0;
      ok_of[s] = 1'b0;
    end
    mismatches = 0;
    beats_checked = 0;
    picks_a = 0;
    picks_b = 0;
    picks_none = 0;
  endfunction

  function void clear_frame();
    pos = '0;
    crc = CRC_INIT;
    magic_cap = '0;
    len_cap = '0;
    crc_cap = '0;
    fault_cap = 1'b0;
  endfunction

  // Fold one accepted image byte into the slot state; queue a run on slot B's last byte
  function void note_byte(logic [7:0] b, logic sid, logic last, logic fault);
    int           p;
    int           l;
    bit           ok;
    logic [15:0]  diff;
    pick_e        win;
    logic         w;
    record_beat_t beat;
    p = pos;
    if (fault) fault_cap = 1'b1;
    if (p < SLOT) begin
      if (p == POS_LEN) len_cap = b;
      l = len_cap;
      if (p == POS_MAGIC_LO) magic_cap[7:0] = b;
      else if (p == POS_MAGIC_HI) magic_cap[15:8] = b;
      else if (p == POS_SEQ_LO) seq_of[sid][7:0] = b;
      else if (p == POS_SEQ_HI) seq_of[sid][15:8] = b;
      if (p >= POS_SEQ_LO && p < HDR_BYTES + l) crc = ccitt_next(crc, b);
      if (p >= HDR_BYTES && p < HDR_BYTES + l && p - HDR_BYTES < REC)
        payload[sid][p - HDR_BYTES] = b;
      if (p == HDR_BYTES + l) crc_cap[7:0] = b;
      else if (p == HDR_BYTES + l + 1) crc_cap[15:8] = b;
      pos = 6'(p + 1);
    end
    if (!last) return;

    // Verdict of the slot named on the last byte
    p = pos;
    l = len_cap;
    ok = !fault_cap && magic_cap == marker && l >= 1 && l <= SLOT - TRAILER
         && p >= l + TRAILER && crc == crc_cap;
    ok_of[sid] = ok;
    kept_len[sid] = ok ? 5'((l < REC) ? l : REC) : 5'd0;
    clear_frame();
    if (sid == 1'b0) return;

    // Pick the newer valid slot; A wins ties and non-negative differences
    diff = seq_of[0] - seq_of[1];
    if (ok_of[0] && ok_of[1]) win = diff[15] ? PICK_B : PICK_A;
    else if (ok_of[0]) win = PICK_A;
    else if (ok_of[1]) win = PICK_B;
    else win = PICK_NONE;

    if (win == PICK_NONE) begin
      beat = '0;
      beat.pick = PICK_NONE;
      beat.last = 1'b1;
      due_beats.push_back(beat);
      picks_none++;
    end else begin
      w = (win == PICK_B);
      if (w) picks_b++;
      else picks_a++;
      for (int k = 0; k < REC; k++) begin
        beat.pick = win;
        beat.seq = seq_of[w];
        beat.a_ok = ok_of[0];
        beat.b_ok = ok_of[1];
        beat.data = (k < kept_len[w]) ? payload[w][k] : 8'h00;
        beat.idx = 5'(k);
        beat.last = (k == REC - 1);
        due_beats.push_back(beat);
      end
    end
    ok_of[0] = 1'b0;
    ok_of[1] = 1'b0;
  endfunction

  task report(string msg);
    mismatches++;
    $display("tb: mismatch: %s", msg);
  endtask

  // Compare one popped result transaction against the oldest due beat
  task check_beat(logic [1:0] pick, logic [15:0] seq, logic a_ok, logic b_ok,
                  logic [7:0] data, logic [4:0] idx, logic last);
    record_beat_t want;
    if (due_beats.size() == 0) begin
      report($sformatf("result with nothing due: pick %0d idx %0d", pick, idx));
      return;
    end
    want = due_beats.pop_front();
    beats_checked++;
    if (pick != want.pick)
      report($sformatf("beat %0d pick_status %0d, want %0d", beats_checked, pick, want.pick));
    if (seq != want.seq)
      report($sformatf("beat %0d chosen_seq %h, want %h", beats_checked, seq, want.seq));
    if (a_ok != want.a_ok)
      report($sformatf("beat %0d a_valid %0b, want %0b", beats_checked, a_ok, want.a_ok));
    if (b_ok != want.b_ok)
      report($sformatf("beat %0d b_valid %0b, want %0b", beats_checked, b_ok, want.b_ok));
    if (data != want.data)
      report($sformatf("beat %0d record_byte %h, want %h", beats_checked, data, want.data));
    if (idx != want.idx)
      report($sformatf("beat %0d byte_index %0d, want %0d", beats_checked, idx, want.idx));
    if (last != want.last)
      report($sformatf("beat %0d run_last %0b, want %0b", beats_checked, last, want.last));
  endtask
endclass

module tb;
  localparam int SLOT_BYTES   = 32;
  localparam int RECORD_LEN   = 24;
  localparam int TAIL_CYCLES  = 12;
  localparam int RANDOM_BYTES = 48;

  typedef record_pick_board #(SLOT_BYTES, RECORD_LEN) board_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        slot_id_i = 1'b0;
  logic        slot_last_i = 1'b0;
  logic        read_fault_i = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  pick_status_o;
  logic [15:0] chosen_seq_o;
  logic        a_valid_o;
  logic        b_valid_o;
  logic [7:0]  record_byte_o;
  logic [4:0]  byte_index_o;
  logic        run_last_o;

  board_t      board;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          bytes_sent = 0;
  logic [15:0] cur_marker = MAGIC_RESET;

  always #5 clk_i = ~clk_i;

  dual_slot_record_selector_core #(
    .SLOT_BYTES (SLOT_BYTES),
    .RECORD_LEN (RECORD_LEN)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .slot_id_i     (slot_id_i),
    .slot_last_i   (slot_last_i),
    .read_fault_i  (read_fault_i),
    .empty         (empty),
    .pop           (pop),
    .pick_status_o (pick_status_o),
    .chosen_seq_o  (chosen_seq_o),
    .a_valid_o     (a_valid_o),
    .b_valid_o     (b_valid_o),
    .record_byte_o (record_byte_o),
    .byte_index_o  (byte_index_o),
    .run_last_o    (run_last_o)
  );

  // Stall the result side at the current rate
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall);
  end

  // Sample every accepted transaction on both sides
  always @(posedge clk_i) begin
    if (rst_ni && push && !full)
      board.note_byte(data_byte_i, slot_id_i, slot_last_i, read_fault_i);
    if (rst_ni && pop && !empty)
      board.check_beat(pick_status_o, chosen_seq_o, a_valid_o, b_valid_o,
                       record_byte_o, byte_index_o, run_last_o);
  end

  // Offer one image byte, idling first at the current rate, and hold it until accepted
  task automatic put_byte(input logic [7:0] b, input logic sid, input logic last,
                          input logic fault);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= b;
    slot_id_i <= sid;
    slot_last_i <= last;
    read_fault_i <= fault;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Build a slot image with a correct CRC, then resize, spoil or fault it as asked
  task automatic send_image(input logic sid, input logic [15:0] mk, input logic [15:0] seq,
                            input int len, input int size_adj, input bit spoil,
                            input int fault_at);
    logic [7:0]  img [$];
    logic [15:0] c;
    int          n;
    int          k;
    img.push_back(mk[7:0]);
    img.push_back(mk[15:8]);
    img.push_back(seq[7:0]);
    img.push_back(seq[15:8]);
    img.push_back(8'(len));
    img.push_back(8'($urandom));
    for (int i = 0; i < len && img.size() < 46; i++) img.push_back(8'($urandom));
    c = CRC_INIT;
    for (int i = POS_SEQ_LO; i < img.size(); i++) c = ccitt_next(c, img[i]);
    img.push_back(c[7:0]);
    img.push_back(c[15:8]);
    n = img.size() + size_adj;
    if (n < 1) n = 1;
    while (img.size() < n) img.push_back(8'($urandom));
    if (spoil && n > 2) begin
      k = $urandom_range(n - 1, 2);
      img[k] = img[k] ^ 8'(1 << $urandom_range(7));
    end
    for (int i = 0; i < n; i++) put_byte(img[i], sid, i == n - 1, i == fault_at);
  endtask

  // Hold the sender until every due result has come, then let the pipeline settle
  task automatic wait_drained();
    push <= 1'b0;
    while (board.due_beats.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_marker(input logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.marker = v;
    cur_marker = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly short payloads, now and then up to 26, past the longest legal length of 24
  function automatic int pick_len();
    return ($urandom_range(9) == 0) ? $urandom_range(26, 7) : $urandom_range(6, 1);
  endfunction

  // One slot image, left as built in half of the draws, otherwise with one defect
  task automatic random_slot(input logic sid, input logic [15:0] seq);
    int          len;
    int          adj;
    int          fault_at;
    bit          spoil;
    logic [15:0] mk;
    len = pick_len();
    adj = 0;
    fault_at = -1;
    spoil = 1'b0;
    mk = cur_marker;
    case ($urandom_range(11))
      0: spoil = 1'b1;
      1: mk = cur_marker ^ 16'(1 << $urandom_range(15));
      2: fault_at = $urandom_range(len + 7);
      3: adj = -int'($urandom_range(len + 7, 1));
      4: len = ($urandom_range(1) == 0) ? 0 : $urandom_range(255, SLOT_BYTES - 7);
      5: adj = $urandom_range(12, 1);
      default: ;
    endcase
    send_image(sid, mk, seq, len, adj, spoil, fault_at);
  endtask

  // A then B with related sequence numbers; sometimes B alone, A twice or A alone
  task automatic random_pair();
    logic [15:0] seq_a;
    logic [15:0] seq_b;
    int          shape;
    seq_a = 16'($urandom);
    case ($urandom_range(4))
      0: seq_b = 16'($urandom);
      1: seq_b = seq_a + 16'($urandom_range(3));
      2: seq_b = seq_a - 16'($urandom_range(3));
      3: seq_b = seq_a ^ 16'h8000;
      default: seq_b = seq_a;
    endcase
    shape = $urandom_range(15);
    if (shape != 0) random_slot(1'b0, seq_a);
    if (shape == 1) random_slot(1'b0, seq_a + 16'd1);
    if (shape != 2) random_slot(1'b1, seq_b);
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [15:0] mk,
                           input int budget);
    int start;
    send_idle = idle;
    recv_stall = stall;
    set_marker(mk);
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      random_pair();
      if ($urandom_range(7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    board = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: winner choice across the sequence range
    send_image(1'b0, MAGIC_RESET, 16'h0000, 1, 0, 0, -1);
    send_image(1'b1, MAGIC_RESET, 16'h0000, 24, 0, 0, -1);
    send_image(1'b0, MAGIC_RESET, 16'h0000, 26, 0, 0, -1);
    send_image(1'b1, MAGIC_RESET, 16'h8000, 2, 0, 0, -1);
    send_image(1'b0, MAGIC_RESET, 16'h7FFF, 3, 0, 0, -1);
    send_image(1'b1, MAGIC_RESET, 16'h0000, 1, 0, 0, -1);
    send_image(1'b0, MAGIC_RESET, 16'hFFFF, 2, 0, 0, -1);
    send_image(1'b1, MAGIC_RESET, 16'h0000, 2, 0, 0, -1);
    // Length out of range on both slots, then fault and bad CRC
    send_image(1'b0, MAGIC_RESET, 16'h0001, 0, 0, 0, -1);
    send_image(1'b1, MAGIC_RESET, 16'h0002, 27, 0, 0, -1);
    send_image(1'b0, MAGIC_RESET, 16'h0003, 2, 0, 0, 0);
    send_image(1'b1, MAGIC_RESET, 16'h0004, 2, 0, 1, -1);
    // Wrong marker on A; short A against an over-long B
    send_image(1'b0, ~MAGIC_RESET, 16'h0005, 1, 0, 0, -1);
    send_image(1'b1, MAGIC_RESET, 16'h0006, 1, 0, 0, -1);
    send_image(1'b0, MAGIC_RESET, 16'h0007, 4, -1, 0, -1);
    send_image(1'b1, MAGIC_RESET, 16'h0008, 24, 10, 0, -1);
    // B with no fresh A; A rewritten before a faulted B
    send_image(1'b1, MAGIC_RESET, 16'h0009, 3, 0, 0, -1);
    send_image(1'b0, MAGIC_RESET, 16'h000A, 2, 0, 0, -1);
    send_image(1'b0, MAGIC_RESET, 16'h000B, 5, 0, 0, -1);
    send_image(1'b1, MAGIC_RESET, 16'h000C, 2, 0, 0, 2);
    wait_drained();

    // Random phases under different marker values and idle mixes
    run_phase(0, 0, 16'h0000, RANDOM_BYTES / 4);
    run_phase(87, 0, 16'hFFFF, RANDOM_BYTES / 4);
    run_phase(0, 87, 16'($urandom), RANDOM_BYTES / 4);
    run_phase(36, 36, MAGIC_RESET, RANDOM_BYTES / 4);

    $display("tb: %0d image bytes sent, %0d result beats checked", bytes_sent,
             board.beats_checked);
    $display("tb: runs picked slot A %0d, slot B %0d, neither %0d; markers 0000, FFFF, A5C3",
             board.picks_a, board.picks_b, board.picks_none);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #3_000_000;
    $display("tb: timeout with %0d result beats still due", board.due_beats.size());
    $display("tb: failure");
    $finish;
  end
endmodule
